// File: rtl/srpv_pkg.sv
package srpv_pkg;

    localparam int SAMPLE_DEPTH = 131072;
    localparam int BAR_TOTAL    = 12;
    localparam int BAR_LEVELS   = 64;

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int IDX_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int BAR_W  = (BAR_TOTAL > 1) ? $clog2(BAR_TOTAL) : 1;
    localparam int LVL_W  = $clog2(BAR_LEVELS);
    localparam int PROD_W = LVL_W + 8;

    localparam int CFG_LEN_W  = 18;
    localparam int CFG_DEB_W  = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (IDX_W > CFG_LEN_W) ? IDX_W : CFG_LEN_W;

    localparam logic [CFG_LEN_W-1:0] RST_RECORD_LENGTH   = 18'd131072;
    localparam logic [CFG_DEB_W-1:0] RST_DEBOUNCE_WINDOW = 20'd200000;
    localparam logic [7:0]           RST_DUTY_FLOOR      = 8'd30;
    localparam logic [7:0]           RST_DUTY_CEILING    = 8'd220;

    localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(SAMPLE_DEPTH);
    localparam logic [BAR_W-1:0] BAR_LAST  = BAR_W'(BAR_TOTAL - 1);
    localparam logic [LVL_W-1:0] LVL_MAX   = LVL_W'(BAR_LEVELS - 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECORD_LENGTH   = 2'd0,
        CFG_DEBOUNCE_WINDOW = 2'd1,
        CFG_DUTY_FLOOR      = 2'd2,
        CFG_DUTY_CEILING    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_LEN_W-1:0] record_length;
        logic [CFG_DEB_W-1:0] debounce_window;
        logic [7:0]           duty_floor;
        logic [7:0]           duty_ceiling;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_cmd_t;

    typedef struct packed {
        mode_t      mode_now;
        logic       sample_valid;
        logic       is_play;
        logic       rd_zero;
        logic [7:0] rec_val;
        logic [3:0] bar_index;
        logic       frame_end;
        logic       session_done;
    } stage_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       sample_valid;
        logic [7:0] pwm_duty;
        logic [3:0] bar_index;
        logic [5:0] bar_height;
        logic       frame_end;
        logic       session_done;
    } res_t;

    // (LEVELS-1)*v/255 through the exact reciprocal form for values below 65535
    function automatic logic [5:0] bar_height_of(input logic [7:0] v);
        logic [PROD_W-1:0] p;
        logic [16:0]       s;
        p = LVL_MAX * v;
        s = 17'(p) + 17'(p >> 8) + 17'd1;
        return s[13:8];
    endfunction

endpackage

// File: rtl/srpv_if.sv
interface srpv_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        button_id;
    logic [31:0] time_stamp;
    logic [11:0] adc_sample;

    modport source (output valid, req_type, button_id, time_stamp, adc_sample, input ready);
    modport sink   (input valid, req_type, button_id, time_stamp, adc_sample, output ready);
endinterface

interface srpv_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode_now;
    logic       sample_valid;
    logic [7:0] pwm_duty;
    logic [3:0] bar_index;
    logic [5:0] bar_height;
    logic       frame_end;
    logic       session_done;

    modport source (output valid, mode_now, sample_valid, pwm_duty, bar_index, bar_height,
                    frame_end, session_done, input ready);
    modport sink   (input valid, mode_now, sample_valid, pwm_duty, bar_index, bar_height,
                    frame_end, session_done, output ready);
endinterface

// File: rtl/srpv_cfg.sv
module srpv_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srpv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpv_pkg::CFG_DATA_W-1:0] cfg_data,
    output srpv_pkg::cfg_t                 cfg
);
    import srpv_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_length   <= RST_RECORD_LENGTH;
            cfg_reg.debounce_window <= RST_DEBOUNCE_WINDOW;
            cfg_reg.duty_floor      <= RST_DUTY_FLOOR;
            cfg_reg.duty_ceiling    <= RST_DUTY_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RECORD_LENGTH:   cfg_reg.record_length   <= cfg_data[CFG_LEN_W-1:0];
                CFG_DEBOUNCE_WINDOW: cfg_reg.debounce_window <= cfg_data[CFG_DEB_W-1:0];
                CFG_DUTY_FLOOR:      cfg_reg.duty_floor      <= cfg_data[7:0];
                CFG_DUTY_CEILING:    cfg_reg.duty_ceiling    <= cfg_data[7:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/srpv_store.sv
module srpv_store (
    input  logic                 clk,
    input  srpv_pkg::mem_cmd_t   cmd,
    output logic [7:0]           rd_data
);
    import srpv_pkg::*;

    logic [7:0] mem [SAMPLE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
            mem[cmd.addr] <= cmd.wdata;
        if (cmd.re)
            rd_data_reg <= mem[cmd.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/srpv_ctrl.sv
module srpv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  srpv_pkg::cfg_t     cfg,
    srpv_req_if.sink           req,
    input  logic               advance,
    output srpv_pkg::mem_cmd_t cmd,
    output srpv_pkg::stage_t   stage,
    output logic               stage_valid
);
    import srpv_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [BAR_W-1:0]  bar_reg, bar_next;
    logic [31:0]       press_reg, press_next;
    logic              stage_valid_reg;
    stage_t            stage_reg, stage_next;

    logic              accept;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  idx_ext;
    logic              at_end;
    logic [31:0]       elapsed;
    logic [IDX_W-1:0]  idx_inc;
    logic [BAR_W-1:0]  bar_inc;
    logic [BAR_W+3:0]  bar_wide;

    assign req.ready = !stage_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign len_ext = (CMP_W'(cfg.record_length) > DEPTH_EXT) ? DEPTH_EXT
                                                             : CMP_W'(cfg.record_length);
    assign idx_ext  = CMP_W'(idx_reg);
    assign at_end   = idx_ext >= len_ext;
    assign elapsed  = req.time_stamp - press_reg;
    assign idx_inc  = idx_reg + 1'b1;
    assign bar_inc  = (bar_reg == BAR_LAST) ? '0 : bar_reg + 1'b1;
    assign bar_wide = {4'b0000, bar_inc};

    always_comb
    begin
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        bar_next   = bar_reg;
        press_next = press_reg;
        stage_next = '0;
        cmd        = '0;
        cmd.addr   = idx_reg[ADDR_W-1:0];
        cmd.wdata  = req.adc_sample[11:4];

        if (accept)
        begin
            if (!req.req_type)
            begin
                if (elapsed >= 32'(cfg.debounce_window))
                begin
                    press_next = req.time_stamp;
                    if (mode_reg == MODE_IDLE)
                    begin
                        mode_next = req.button_id ? MODE_PLAY : MODE_REC;
                        idx_next  = '0;
                        bar_next  = '0;
                    end
                end
            end
            else if (mode_reg == MODE_REC || mode_reg == MODE_PLAY)
            begin
                if (at_end)
                begin
                    mode_next               = MODE_IDLE;
                    stage_next.session_done = 1'b1;
                end
                else
                begin
                    idx_next                = idx_inc;
                    bar_next                = bar_inc;
                    stage_next.sample_valid = 1'b1;
                    stage_next.bar_index    = bar_wide[3:0];
                    stage_next.frame_end    = (bar_inc == BAR_LAST);
                    if (mode_reg == MODE_REC)
                    begin
                        cmd.we             = 1'b1;
                        stage_next.rec_val = req.adc_sample[11:4];
                        // writes run up from zero, so the fill count is a high-water mark
                        if (idx_inc > fill_reg)
                            fill_next = idx_inc;
                    end
                    else
                    begin
                        cmd.re             = 1'b1;
                        stage_next.is_play = 1'b1;
                        stage_next.rd_zero = idx_reg >= fill_reg;
                    end
                end
            end
        end
        stage_next.mode_now = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            idx_reg         <= '0;
            fill_reg        <= '0;
            bar_reg         <= '0;
            press_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            bar_reg   <= bar_next;
            press_reg <= press_next;
            if (accept)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

    assign stage       = stage_reg;
    assign stage_valid = stage_valid_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= IDX_W'(SAMPLE_DEPTH))
        else $error("fill count beyond store depth");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.we && cmd.re))
        else $error("store read and write in the same cycle");

    a_rec_to_play: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_REC |=> mode_reg != MODE_PLAY)
        else $error("recording switched straight to playback");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg && $stable(stage_reg))
        else $error("stalled stage word changed");
`endif

endmodule

// File: rtl/srpv_out.sv
module srpv_out (
    input  logic             clk,
    input  logic             rst_n,
    input  srpv_pkg::cfg_t   cfg,
    input  srpv_pkg::stage_t stage,
    input  logic             stage_valid,
    input  logic [7:0]       rd_data,
    output logic             advance,
    srpv_res_if.source       res
);
    import srpv_pkg::*;

    logic       out_valid_reg;
    res_t       res_reg, res_next;
    logic [7:0] sample;
    logic [7:0] duty_lo;
    logic [7:0] duty;

    assign advance = !out_valid_reg || res.ready;

    // entries past the fill count were never written and read as zero
    assign sample  = stage.is_play ? (stage.rd_zero ? 8'd0 : rd_data) : stage.rec_val;
    assign duty_lo = (sample < cfg.duty_floor) ? cfg.duty_floor : sample;
    assign duty    = (duty_lo > cfg.duty_ceiling) ? cfg.duty_ceiling : duty_lo;

    always_comb
    begin
        res_next              = '0;
        res_next.mode_now     = stage.mode_now;
        res_next.sample_valid = stage.sample_valid;
        res_next.bar_index    = stage.bar_index;
        res_next.frame_end    = stage.frame_end;
        res_next.session_done = stage.session_done;
        if (stage.sample_valid)
        begin
            res_next.bar_height = bar_height_of(sample);
            if (stage.is_play)
                res_next.pwm_duty = duty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
            res_reg <= res_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.mode_now     = res_reg.mode_now;
    assign res.sample_valid = res_reg.sample_valid;
    assign res.pwm_duty     = res_reg.pwm_duty;
    assign res.bar_index    = res_reg.bar_index;
    assign res.bar_height   = res_reg.bar_height;
    assign res.frame_end    = res_reg.frame_end;
    assign res.session_done = res_reg.session_done;

`ifndef SYNTHESIS
    a_done_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && stage.session_done |-> !stage.sample_valid)
        else $error("session end word also carries a sample");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && stage.session_done |-> stage.mode_now == MODE_IDLE)
        else $error("session end word not idle");

    a_duty_play_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.pwm_duty != 8'd0 |-> res_reg.mode_now == MODE_PLAY)
        else $error("duty given outside playback");
`endif

endmodule

// File: rtl/sample_record_playback_vu_core.sv
// Record/playback controller over a 131072 x 8 sample store with VU bar outputs. Button
// events and sample ticks share the request channel and each gives exactly one result word;
// a new request is taken every cycle unless the result side stalls, and its result word is
// presented from the output register, after the stage register that holds the synchronous
// store read, so the block sustains one item per clock unless the result side stalls. The
// store needs no clearing pass after reset: a fill count marks how far recording has reached
// and playback beyond it reads zero. Configuration writes take effect on the next cycle and
// must be made while no request is in flight.
module sample_record_playback_vu_core (
    input  logic                           clk,
    input  logic                           rst_n,
    srpv_req_if.sink                       req,
    srpv_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [srpv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srpv_pkg::*;

    cfg_t       cfg;
    mem_cmd_t   cmd;
    stage_t     stage;
    logic       stage_valid;
    logic       advance;
    logic [7:0] rd_data;

    srpv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srpv_store u_store (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    srpv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .advance     (advance),
        .cmd         (cmd),
        .stage       (stage),
        .stage_valid (stage_valid)
    );

    srpv_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage       (stage),
        .stage_valid (stage_valid),
        .rd_data     (rd_data),
        .advance     (advance),
        .res         (res)
    );

endmodule

// File: tb/sample_record_playback_vu_core_tb.sv
module sample_record_playback_vu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srpv_pkg::*;

    localparam logic REQ_BUTTON = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic BTN_REC    = 1'b0;
    localparam logic BTN_PLAY   = 1'b1;

    localparam int PHASE_WORDS    = 235;
    localparam int NUM_PHASES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic        req_type;
        logic        button_id;
        logic [31:0] time_stamp;
        logic [11:0] adc_sample;
    } req_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_acc = 1'b0;

    srpv_req_if req_if();
    srpv_res_if res_if();

    sample_record_playback_vu_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow of the recorder state and its registers
    logic [7:0]  shadow_store [SAMPLE_DEPTH];
    int unsigned wr_pos;
    int unsigned rd_pos;
    mode_t       shadow_mode;
    logic [31:0] last_press;
    logic [17:0] len_reg;
    logic [19:0] deb_reg;
    logic [7:0]  floor_reg;
    logic [7:0]  ceil_reg;

    req_word_t   pending_words [$];
    res_t        due_results [$];
    int          words_open = 0;
    int unsigned words_sent = 0;
    int unsigned errors = 0;
    int unsigned settings_applied = 0;
    int unsigned samples_recorded = 0;
    int unsigned samples_played = 0;
    int unsigned sessions_ended = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic [31:0] clock_us = 32'd0;

    function automatic res_t step_recorder(req_word_t w);
        res_t        r;
        int unsigned limit;
        int unsigned count;
        logic [7:0]  v;
        logic [7:0]  duty;
        logic [31:0] gap;
        logic        handled;
        r       = '0;
        handled = 1'b0;
        count   = 0;
        v       = 8'd0;
        limit   = (len_reg > SAMPLE_DEPTH) ? SAMPLE_DEPTH : len_reg;
        gap     = w.time_stamp - last_press;
        if (w.req_type == REQ_BUTTON)
        begin
            if (gap >= 32'(deb_reg))
            begin
                last_press = w.time_stamp;
                if (shadow_mode == MODE_IDLE)
                begin
                    if (w.button_id == BTN_REC)
                    begin
                        shadow_mode = MODE_REC;
                        wr_pos      = 0;
                    end
                    else
                    begin
                        shadow_mode = MODE_PLAY;
                        rd_pos      = 0;
                    end
                end
            end
        end
        else if (shadow_mode == MODE_REC)
        begin
            if (wr_pos >= limit)
            begin
                shadow_mode    = MODE_IDLE;
                r.session_done = 1'b1;
                sessions_ended++;
            end
            else
            begin
                v                    = w.adc_sample[11:4];
                shadow_store[wr_pos] = v;
                wr_pos++;
                count   = wr_pos;
                handled = 1'b1;
                samples_recorded++;
            end
        end
        else if (shadow_mode == MODE_PLAY)
        begin
            if (rd_pos >= limit)
            begin
                shadow_mode    = MODE_IDLE;
                r.session_done = 1'b1;
                sessions_ended++;
            end
            else
            begin
                v = shadow_store[rd_pos];
                rd_pos++;
                count = rd_pos;
                // floor first, so the ceiling wins when they cross
                duty = v;
                if (duty < floor_reg)
                    duty = floor_reg;
                if (duty > ceil_reg)
                    duty = ceil_reg;
                r.pwm_duty = duty;
                handled    = 1'b1;
                samples_played++;
            end
        end
        if (handled)
        begin
            r.sample_valid = 1'b1;
            r.bar_index    = 4'(count % BAR_TOTAL);
            r.bar_height   = 6'(((BAR_LEVELS - 1) * int'(v)) / 255);
            r.frame_end    = ((count % BAR_TOTAL) == BAR_TOTAL - 1);
        end
        r.mode_now = shadow_mode;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void push_word(logic rt, logic btn, logic [31:0] ts, logic [11:0] adc);
        req_word_t w;
        w.req_type   = rt;
        w.button_id  = btn;
        w.time_stamp = ts;
        w.adc_sample = adc;
        pending_words.push_back(w);
        words_open++;
        words_sent++;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // call only at a falling edge with nothing in flight
    task automatic apply_settings(logic [17:0] l, logic [19:0] d, logic [7:0] f, logic [7:0] c);
        write_reg(CFG_RECORD_LENGTH, CFG_DATA_W'(l));
        write_reg(CFG_DEBOUNCE_WINDOW, CFG_DATA_W'(d));
        write_reg(CFG_DUTY_FLOOR, CFG_DATA_W'(f));
        write_reg(CFG_DUTY_CEILING, CFG_DATA_W'(c));
        cfg_we    <= 1'b0;
        len_reg   = l;
        deb_reg   = d;
        floor_reg = f;
        ceil_reg  = c;
        settings_applied++;
    endtask

    task automatic drain();
        while (words_open != 0)
            @(negedge clk);
    endtask

    task automatic random_phase();
        int unsigned eff;
        int unsigned ticks;
        int unsigned start;
        logic        btn;
        start = words_sent;
        eff   = (len_reg > SAMPLE_DEPTH) ? SAMPLE_DEPTH : len_reg;
        while (words_sent - start < PHASE_WORDS)
        begin
            if ($urandom_range(99) < 70)
            begin
                btn = 1'($urandom_range(1));
                // bounce ahead of the real press
                if ($urandom_range(99) < 20)
                    push_word(REQ_BUTTON, 1'($urandom_range(1)),
                              clock_us + $urandom_range(0, deb_reg),
                              12'($urandom_range(4095)));
                clock_us = clock_us + deb_reg + $urandom_range(0, 500);
                push_word(REQ_BUTTON, btn, clock_us, 12'($urandom_range(4095)));
                ticks = ((eff < 40) ? eff : 40) + 1;
                // cut some sessions short
                if ($urandom_range(99) < 15)
                    ticks = $urandom_range(0, ticks);
                repeat (ticks)
                    push_word(REQ_TICK, 1'($urandom_range(1)), $urandom(),
                              12'($urandom_range(4095)));
            end
            else
            begin
                push_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                          12'($urandom_range(4095)));
            end
        end
    endtask

    // driver: present the next word once the current one is taken
    always @(negedge clk)
    begin : drive
        req_word_t w;
        res_if.ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && (!req_if.valid || req_acc))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                w = pending_words.pop_front();
                req_if.valid      <= 1'b1;
                req_if.req_type   <= w.req_type;
                req_if.button_id  <= w.button_id;
                req_if.time_stamp <= w.time_stamp;
                req_if.adc_sample <= w.adc_sample;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin : watch
        res_t      want;
        req_word_t w;
        int        quiet_cycles;
        logic      moved;
        if (rst_n)
        begin
            moved   = 1'b0;
            req_acc <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                w.req_type   = req_if.req_type;
                w.button_id  = req_if.button_id;
                w.time_stamp = req_if.time_stamp;
                w.adc_sample = req_if.adc_sample;
                due_results.push_back(step_recorder(w));
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready)
            begin
                moved = 1'b1;
                words_open--;
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, mode %0d done %0d",
                             $time, res_if.mode_now, res_if.session_done);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("mode_now", 32'(want.mode_now), 32'(res_if.mode_now));
                    check_field("sample_valid", 32'(want.sample_valid),
                                32'(res_if.sample_valid));
                    check_field("pwm_duty", 32'(want.pwm_duty), 32'(res_if.pwm_duty));
                    check_field("bar_index", 32'(want.bar_index), 32'(res_if.bar_index));
                    check_field("bar_height", 32'(want.bar_height), 32'(res_if.bar_height));
                    check_field("frame_end", 32'(want.frame_end), 32'(res_if.frame_end));
                    check_field("session_done", 32'(want.session_done),
                                32'(res_if.session_done));
                end
            end
            if (moved || words_open == 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("sample_record_playback_vu_core regression: fail");
                $finish;
            end
        end
        else
        begin
            req_acc      <= 1'b0;
            quiet_cycles = 0;
        end
    end

    initial
    begin : stimulus
        int p;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_BUTTON;
        req_if.button_id  = BTN_REC;
        req_if.time_stamp = 32'd0;
        req_if.adc_sample = 12'd0;
        res_if.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RECORD_LENGTH;
        cfg_data          = '0;
        foreach (shadow_store[i])
            shadow_store[i] = 8'd0;
        wr_pos      = 0;
        rd_pos      = 0;
        shadow_mode = MODE_IDLE;
        last_press  = 32'd0;
        len_reg     = RST_RECORD_LENGTH;
        deb_reg     = RST_DEBOUNCE_WINDOW;
        floor_reg   = RST_DUTY_FLOOR;
        ceil_reg    = RST_DUTY_CEILING;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle tick, bounced press, playback of the untouched store
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'hFFF);
        push_word(REQ_BUTTON, BTN_PLAY, 32'd100, 12'h000);
        push_word(REQ_BUTTON, BTN_PLAY, 32'd200000, 12'h000);
        push_word(REQ_TICK, BTN_PLAY, 32'hFFFF_FFFF, 12'h123);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'hABC);
        push_word(REQ_BUTTON, BTN_REC, 32'd400000, 12'h000);
        drain();

        // short sessions with the floor above the ceiling
        apply_settings(18'd2, 20'd0, 8'd200, 8'd100);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h000);
        push_word(REQ_BUTTON, BTN_REC, 32'd400000, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'hFFF);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h00F);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h800);
        push_word(REQ_BUTTON, BTN_PLAY, 32'd400000, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h000);
        drain();

        // zero length, widest window, time wrapping past zero
        apply_settings(18'd0, 20'hFFFFF, 8'd0, 8'd255);
        push_word(REQ_BUTTON, BTN_REC, 32'hFFFF_FFFF, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'h555);
        push_word(REQ_BUTTON, BTN_REC, 32'd0, 12'h000);
        push_word(REQ_BUTTON, BTN_PLAY, 32'h000F_FFFE, 12'h000);
        push_word(REQ_TICK, BTN_REC, 32'd0, 12'hAAA);
        drain();
        clock_us = 32'h000F_FFFE;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 57; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            case (p)
                0: apply_settings(18'd5, 20'd0, 8'd30, 8'd220);
                1: apply_settings(18'd12, 20'd1000, 8'd0, 8'd255);
                2: apply_settings(18'd1, 20'hFFFFF, 8'd255, 8'd255);
                3: apply_settings(18'h3FFFF, 20'd200000, 8'd100, 8'd50);
                4: apply_settings(18'(SAMPLE_DEPTH), 20'd0, 8'd0, 8'd0);
                5: apply_settings(18'd24, 20'd1000000, 8'd128, 8'd128);
                default: apply_settings(18'($urandom_range(1, 40)),
                                        20'($urandom_range(0, 3000)),
                                        8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            random_phase();
            drain();
        end

        // hold a little longer to catch stray result words
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d request words across %0d register settings and four idle mixes",
                 words_sent, settings_applied);
        $display("%0d samples recorded, %0d played, %0d sessions ended, %0d mismatches",
                 samples_recorded, samples_played, sessions_ended, errors);
        if (errors == 0 && due_results.size() == 0)
            $display("sample_record_playback_vu_core regression: pass");
        else
            $display("sample_record_playback_vu_core regression: fail");
        $finish;
    end

endmodule
